// ===== design/key_value_multimap_table_defines.svh =====
// Assertion macros for the key/value multimap table.
// Used by key_value_multimap_table.sv; expects clk and arst_n in scope.
`ifndef KEY_VALUE_MULTIMAP_TABLE_DEFINES_SVH
`define KEY_VALUE_MULTIMAP_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

`define KVMT_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

`define KVMT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define KVMT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define KVMT_ASSERT_ALWAYS(lbl, cond)
`define KVMT_ASSERT_IMP(lbl, ante, cons)
`define KVMT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== design/kvmt_pkg.sv =====
// Shared sizes, codes and types of the key/value multimap table.
// No dependencies.
package kvmt_pkg;

	localparam int CAPACITY   = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 64;
	localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_FIND   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		STAT_ADDED     = 3'd0,
		STAT_FULL      = 3'd1,
		STAT_REMOVED   = 3'd2,
		STAT_NOT_FOUND = 3'd3,
		STAT_FOUND     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_CHECK,
		S_RESOLVE,
		S_EMIT,
		S_WAIT
	} state_t;

endpackage

// ===== design/key_value_multimap_table.sv =====
// Key/value multimap table: valid flags in flops, keys and values in memories.
// Depends on kvmt_pkg and key_value_multimap_table_defines.svh.
//
// A request is taken when start is high and busy is low. An add writes the lowest
// free slot and answers in the next cycle without raising busy, so adds can follow
// every cycle. A remove or find reads the key memory one slot per cycle, then
// reads the value memory once per matching slot; busy stays high through the
// scan, check and resolve states, and through the emit and wait states on a match.
// Results appear on the result ports for one cycle each with result_strobe and cannot be held off.
`include "key_value_multimap_table_defines.svh"

module key_value_multimap_table (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic [1:0]                              command,
	input  logic signed [kvmt_pkg::KEY_BITS-1:0]    key_in,
	input  logic [kvmt_pkg::VALUE_BITS-1:0]         value_in,
	output logic                                    result_strobe,
	output logic [2:0]                              status,
	output logic signed [kvmt_pkg::KEY_BITS-1:0]    key_out,
	output logic [kvmt_pkg::VALUE_BITS-1:0]         value_out,
	output logic [kvmt_pkg::CNT_W-1:0]              occupancy,
	output logic                                    last
);
	import kvmt_pkg::*;

	state_t state_q, state_d;

	logic [CAPACITY-1:0]   valid_q, match_q, pending_q;
	logic [CAPACITY-1:0]   pick_onehot, pending_rest;
	cnt_t                  count_q, hits_q, occ_q;
	idx_t                  scan_idx_q, scan_idx_s1, free_idx, pick_idx;
	logic                  free_found, scan_s1, emit_s1, last_s1;
	logic                  accept, mem_we;
	logic [1:0]            cmd_q;
	logic [KEY_BITS-1:0]   key_q;

	logic [KEY_BITS-1:0]   key_mem [CAPACITY];
	logic [VALUE_BITS-1:0] value_mem [CAPACITY];
	logic [KEY_BITS-1:0]   key_rd_q;
	logic [VALUE_BITS-1:0] value_rd_q;

	logic                  strobe_q, last_q;
	logic [2:0]            status_q;
	logic [KEY_BITS-1:0]   key_out_q;
	logic [VALUE_BITS-1:0] value_out_q;
	cnt_t                  occ_out_q;

	assign busy          = (state_q != S_IDLE);
	assign accept        = start && (state_q == S_IDLE);
	assign result_strobe = strobe_q;
	assign status        = status_q;
	assign key_out       = key_out_q;
	assign value_out     = value_out_q;
	assign occupancy     = occ_out_q;
	assign last          = last_q;

	// lowest free slot and lowest pending match
	assign pick_onehot  = pending_q & (~pending_q + 1'b1);
	assign pending_rest = pending_q & ~pick_onehot;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		pick_idx   = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
			if (pick_onehot[i]) begin
				pick_idx = IDX_W'(i);
			end
		end
	end

	assign mem_we = accept && (command == CMD_ADD) && free_found;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && (command == CMD_REMOVE || command == CMD_FIND)) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_idx_q == IDX_W'(CAPACITY - 1)) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK:   state_d = S_RESOLVE;
			S_RESOLVE: state_d = (hits_q == '0) ? S_IDLE : S_EMIT;
			S_EMIT: begin
				if (pending_rest == '0) begin
					state_d = S_WAIT;
				end
			end
			S_WAIT:    state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			valid_q    <= '0;
			match_q    <= '0;
			pending_q  <= '0;
			count_q    <= '0;
			hits_q     <= '0;
			scan_idx_q <= '0;
			scan_s1    <= 1'b0;
			emit_s1    <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			scan_s1  <= (state_q == S_SCAN);
			emit_s1  <= (state_q == S_EMIT);
			strobe_q <= (accept && command == CMD_ADD)
				|| (state_q == S_RESOLVE && hits_q == '0)
				|| emit_s1;

			if (accept) begin
				match_q    <= '0;
				hits_q     <= '0;
				scan_idx_q <= '0;
				if (mem_we) begin
					valid_q[free_idx] <= 1'b1;
					count_q           <= count_q + 1'b1;
				end
			end

			if (state_q == S_SCAN) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end

			if (scan_s1 && valid_q[scan_idx_s1] && key_rd_q == key_q) begin
				match_q[scan_idx_s1] <= 1'b1;
				hits_q               <= hits_q + 1'b1;
			end

			if (state_q == S_RESOLVE && hits_q != '0) begin
				pending_q <= match_q;
				if (cmd_q == CMD_REMOVE) begin
					valid_q <= valid_q & ~match_q;
					count_q <= count_q - hits_q;
				end
			end

			if (state_q == S_EMIT) begin
				pending_q <= pending_rest;
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_idx_s1 <= scan_idx_q;
		last_s1     <= (pending_rest == '0);
		if (accept) begin
			cmd_q <= command;
			key_q <= key_in;
		end
		if (state_q == S_RESOLVE) begin
			occ_q <= (cmd_q == CMD_REMOVE) ? count_q - hits_q : count_q;
		end

		if (accept && command == CMD_ADD) begin
			status_q    <= free_found ? STAT_ADDED : STAT_FULL;
			key_out_q   <= key_in;
			value_out_q <= free_found ? value_in : '0;
			occ_out_q   <= free_found ? count_q + 1'b1 : count_q;
			last_q      <= 1'b1;
		end else if (state_q == S_RESOLVE && hits_q == '0) begin
			status_q    <= STAT_NOT_FOUND;
			key_out_q   <= key_q;
			value_out_q <= '0;
			occ_out_q   <= count_q;
			last_q      <= 1'b1;
		end else if (emit_s1) begin
			status_q    <= (cmd_q == CMD_REMOVE) ? STAT_REMOVED : STAT_FOUND;
			key_out_q   <= key_q;
			value_out_q <= value_rd_q;
			occ_out_q   <= occ_q;
			last_q      <= last_s1;
		end
	end

	// key and value memories, registered reads
	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[free_idx] <= key_in;
		end
		key_rd_q <= key_mem[scan_idx_q];
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			value_mem[free_idx] <= value_in;
		end
		value_rd_q <= value_mem[pick_idx];
	end

	`KVMT_ASSERT_ALWAYS(a_count_tracks_valid, $countones(valid_q) == count_q)
	`KVMT_ASSERT_NEXT(a_add_answers, start && !busy && command == CMD_ADD, result_strobe)
	`KVMT_ASSERT_IMP(a_emit_in_drain, emit_s1, state_q == S_EMIT || state_q == S_WAIT)
	`KVMT_ASSERT_IMP(a_pending_in_match, state_q == S_EMIT, (pending_q & ~match_q) == '0)

endmodule

// ===== test/key_value_multimap_table_checker.sv =====
// Checker for the key/value multimap table: mirrors the table, predicts every result
// of each accepted request and compares the result stream field by field.
// Depends on kvmt_pkg.
`timescale 1ns / 100ps

module key_value_multimap_table_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic                                 busy,
	input  logic [1:0]                           command,
	input  logic signed [kvmt_pkg::KEY_BITS-1:0] key_in,
	input  logic [kvmt_pkg::VALUE_BITS-1:0]      value_in,
	input  logic                                 result_strobe,
	input  logic [2:0]                           status,
	input  logic signed [kvmt_pkg::KEY_BITS-1:0] key_out,
	input  logic [kvmt_pkg::VALUE_BITS-1:0]      value_out,
	input  logic [kvmt_pkg::CNT_W-1:0]           occupancy,
	input  logic                                 last,
	output int                                   mismatch_count,
	output int                                   outstanding
);
	import kvmt_pkg::*;

	typedef struct {
		status_t               status;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
		cnt_t                  occupancy;
		logic                  last;
	} kv_result_t;

	logic                  slot_used [CAPACITY];
	logic [KEY_BITS-1:0]   slot_key  [CAPACITY];
	logic [VALUE_BITS-1:0] slot_value[CAPACITY];
	cnt_t                  entry_total;
	kv_result_t            expected_results[$];
	kv_result_t            head;
	int                    fail_count = 0;

	task automatic predict_request(input cmd_t cmd, input logic [KEY_BITS-1:0] key,
			input logic [VALUE_BITS-1:0] value);
		kv_result_t hits[$];
		kv_result_t r;
		int         slot;
		int         i;
		slot = -1;
		if (cmd == CMD_ADD) begin
			for (i = 0; i < CAPACITY; i++)
				if (!slot_used[i] && slot < 0)
					slot = i;
			r.key = key;
			if (slot < 0) begin
				r.status = STAT_FULL;
				r.value  = '0;
			end else begin
				slot_used[slot]  = 1'b1;
				slot_key[slot]   = key;
				slot_value[slot] = value;
				entry_total++;
				r.status = STAT_ADDED;
				r.value  = value;
			end
			hits.push_back(r);
		end else if (cmd == CMD_REMOVE || cmd == CMD_FIND) begin
			for (i = 0; i < CAPACITY; i++) begin
				if (slot_used[i] && slot_key[i] == key) begin
					r.status = (cmd == CMD_REMOVE) ? STAT_REMOVED : STAT_FOUND;
					r.key    = slot_key[i];
					r.value  = slot_value[i];
					hits.push_back(r);
					if (cmd == CMD_REMOVE) begin
						slot_used[i] = 1'b0;
						entry_total--;
					end
				end
			end
			if (hits.size() == 0) begin
				r.status = STAT_NOT_FOUND;
				r.key    = key;
				r.value  = '0;
				hits.push_back(r);
			end
		end
		// occupancy is the count once the whole request is done
		for (i = 0; i < hits.size(); i++) begin
			r           = hits[i];
			r.occupancy = entry_total;
			r.last      = (i == hits.size() - 1);
			expected_results.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CAPACITY; i++)
				slot_used[i] = 1'b0;
			entry_total = '0;
			expected_results.delete();
		end else begin
			if (result_strobe) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result status %0d key %h value %h", $time,
						status, key_out, value_out);
					fail_count++;
				end else begin
					head = expected_results.pop_front();
					if (status !== head.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							head.status, status);
						fail_count++;
					end
					if (key_out !== head.key) begin
						$display("%0t: key_out expected %h actual %h", $time,
							head.key, key_out);
						fail_count++;
					end
					if (value_out !== head.value) begin
						$display("%0t: value_out expected %h actual %h", $time,
							head.value, value_out);
						fail_count++;
					end
					if (occupancy !== head.occupancy) begin
						$display("%0t: occupancy expected %0d actual %0d", $time,
							head.occupancy, occupancy);
						fail_count++;
					end
					if (last !== head.last) begin
						$display("%0t: last expected %0d actual %0d", $time,
							head.last, last);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				predict_request(cmd_t'(command), key_in, value_in);
		end
		mismatch_count <= fail_count;
		outstanding    <= expected_results.size();
	end

endmodule

// ===== test/key_value_multimap_table_test.sv =====
// Testbench top for the key/value multimap table: clock, reset, directed and random
// requests with random gaps, and the final verdict.
// Depends on kvmt_pkg, key_value_multimap_table and key_value_multimap_table_checker.
`timescale 1ns / 100ps

module key_value_multimap_table_test;
	import kvmt_pkg::*;

	localparam int DRAIN_CYCLES = 2 * CAPACITY + 12;
	localparam int PHASE_ITEMS  = 45;

	logic                       clk      = 1'b0;
	logic                       arst_n   = 1'b0;
	logic                       start    = 1'b0;
	logic [1:0]                 command  = CMD_NONE;
	logic signed [KEY_BITS-1:0] key_in   = '0;
	logic [VALUE_BITS-1:0]      value_in = '0;
	logic                       busy;
	logic                       result_strobe;
	logic [2:0]                 status;
	logic signed [KEY_BITS-1:0] key_out;
	logic [VALUE_BITS-1:0]      value_out;
	logic [CNT_W-1:0]           occupancy;
	logic                       last;
	int                         mismatches;
	int                         outstanding;

	bit                  gaps_on = 1'b1;
	logic [KEY_BITS-1:0] key_pool[6];

	key_value_multimap_table u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.key_in       (key_in),
		.value_in     (value_in),
		.result_strobe(result_strobe),
		.status       (status),
		.key_out      (key_out),
		.value_out    (value_out),
		.occupancy    (occupancy),
		.last         (last)
	);

	key_value_multimap_table_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.key_in        (key_in),
		.value_in      (value_in),
		.result_strobe (result_strobe),
		.status        (status),
		.key_out       (key_out),
		.value_out     (value_out),
		.occupancy     (occupancy),
		.last          (last),
		.mismatch_count(mismatches),
		.outstanding   (outstanding)
	);

	always #6 clk = ~clk;

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [VALUE_BITS-1:0] pick_value();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	function automatic logic [KEY_BITS-1:0] pick_key();
		if ($urandom_range(0, 99) < 85)
			return key_pool[$urandom_range(0, 5)];
		return $urandom;
	endfunction

	function automatic cmd_t pick_command(input int add_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < add_pct)
			return CMD_ADD;
		if (r < add_pct + (96 - add_pct) / 2)
			return CMD_REMOVE;
		if (r < 96)
			return CMD_FIND;
		return CMD_NONE;
	endfunction

	// hold the request until busy is low at an edge, then, if the random gap is not zero, drop start for that gap
	task automatic send_request(input cmd_t cmd, input logic [KEY_BITS-1:0] key,
			input logic [VALUE_BITS-1:0] value);
		int gap;
		start    <= 1'b1;
		command  <= cmd;
		key_in   <= key;
		value_in <= value;
		do @(posedge clk); while (busy);
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic refill_pool();
		for (int i = 0; i < 6; i++)
			key_pool[i] = $urandom;
		key_pool[$urandom_range(0, 5)] = 32'h8000_0000;
		key_pool[$urandom_range(0, 5)] = 32'h7fff_ffff;
		if ($urandom_range(0, 1))
			key_pool[$urandom_range(0, 5)] = '0;
		else
			key_pool[$urandom_range(0, 5)] = '1;
	endtask

	initial begin
		int   i;
		int   phase;
		int   counted;
		int   add_pct[5];
		bit   phase_gaps[5];
		cmd_t cmd;

		add_pct    = '{70, 30, 85, 40, 55};
		phase_gaps = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// empty table, extreme keys, lowest free slot, duplicates, full table
		send_request(CMD_FIND, 32'd7, '0);
		send_request(CMD_REMOVE, 32'd7, '1);
		send_request(CMD_ADD, 32'h8000_0000, '0);
		send_request(CMD_ADD, 32'h7fff_ffff, '1);
		send_request(CMD_ADD, '0, 64'haaaa_aaaa_aaaa_aaaa);
		send_request(CMD_ADD, '1, 64'h5555_5555_5555_5555);
		send_request(CMD_NONE, 32'h1234_5678, 64'h0123_4567_89ab_cdef);
		send_request(CMD_FIND, 32'h8000_0000, '0);
		send_request(CMD_REMOVE, '0, '0);
		send_request(CMD_ADD, 32'd9, pick_value());
		for (i = 0; i < CAPACITY - 4; i++)
			send_request(CMD_ADD, 32'd9, pick_value());
		send_request(CMD_ADD, 32'h7fff_ffff, '1);
		send_request(CMD_FIND, 32'd9, '0);
		send_request(CMD_REMOVE, 32'd9, '0);

		for (phase = 0; phase < 5; phase++) begin
			gaps_on = phase_gaps[phase];
			refill_pool();
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				cmd = pick_command(add_pct[phase]);
				send_request(cmd, pick_key(), pick_value());
				if (cmd != CMD_NONE)
					counted++;
			end
		end

		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
